// File: hdl/tcp_uri_host_port_splitter_macros.svh
// assertion macros used by the port checker file
`ifndef TCP_URI_HOST_PORT_SPLITTER_MACROS_SVH
`define TCP_URI_HOST_PORT_SPLITTER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TUHPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tuhps check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define TUHPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tuhps check failed");

`endif

// File: hdl/tuhps_pkg.sv
// shared types, constants and helpers of the uri host/port splitter
package tuhps_pkg;

	localparam int MAX_URL_LENGTH = 4096;
	localparam int POS_W = $clog2(MAX_URL_LENGTH + 1);
	localparam int FIELD_W = 12;
	localparam int PREFIX_LEN = 10;
	localparam int TAIL_MARGIN = 4;
	// highest last-character position whose length still passes the length check
	localparam int LAST_POS_MAX = MAX_URL_LENGTH - TAIL_MARGIN - 1;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_beat_t;

	typedef struct packed {
		logic               uri_ok;
		logic [FIELD_W-1:0] host_length;
		logic [FIELD_W-1:0] port_start;
		logic [FIELD_W-1:0] port_length;
	} result_beat_t;

	typedef struct packed {
		logic               in_port_part;
		logic               port_seen;
		logic               path_seen;
		logic               bad_syntax;
		logic               inside_brackets;
		logic [FIELD_W-1:0] host_len;
		logic [FIELD_W-1:0] port_start;
		logic [FIELD_W-1:0] port_len;
	} scan_state_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

	// expected scheme text "opc.tcp://", lower case
	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0: r = 8'h6f;
			4'd1: r = 8'h70;
			4'd2: r = 8'h63;
			4'd3: r = 8'h2e;
			4'd4: r = 8'h74;
			4'd5: r = 8'h63;
			4'd6: r = 8'h70;
			4'd7: r = CH_COLON;
			4'd8: r = CH_SLASH;
			4'd9: r = CH_SLASH;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/tuhps_scan.sv
// host/port scanner: next scan state from one character
module tuhps_scan (
	input  logic                        en,
	input  logic [7:0]                  ch,
	input  logic [tuhps_pkg::POS_W-1:0] pos,
	input  tuhps_pkg::scan_state_t      st,
	output tuhps_pkg::scan_state_t      nxt
);
	import tuhps_pkg::*;

	logic is_digit;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

	always_comb begin
		nxt = st;
		if (en) begin
			if (st.in_port_part) begin
				if (is_digit) begin
					if (!st.port_seen) begin
						nxt.port_seen = 1'b1;
						nxt.port_start = FIELD_W'(pos);
					end
				end else if (ch == CH_SLASH && !st.bad_syntax) begin
					if (!st.port_seen) begin
						nxt.bad_syntax = 1'b1;
					end else begin
						nxt.port_len = FIELD_W'(pos) - st.port_start;
						nxt.path_seen = 1'b1;
					end
				end else if (!st.port_seen || !st.path_seen) begin
					nxt.bad_syntax = 1'b1;
				end
			end else begin
				if (ch == CH_COLON && !st.inside_brackets) begin
					nxt.host_len = FIELD_W'(pos - POS_W'(PREFIX_LEN));
					nxt.in_port_part = 1'b1;
				end else if (ch == CH_LBRACK) begin
					nxt.inside_brackets = 1'b1;
				end else if (ch == CH_RBRACK) begin
					if (!st.inside_brackets) begin
						nxt.bad_syntax = 1'b1;
					end else begin
						nxt.inside_brackets = 1'b0;
					end
				end
			end
		end
	end

endmodule

// File: hdl/tcp_uri_host_port_splitter.sv
// Splits an "opc.tcp://host:port/path" uri that streams in one character per beat,
// the final character flagged by last. One character is taken every cycle unless
// the input side stalls. Each beat waits in the input register, and the result
// of a last beat is loaded into the result register when the beat moves on. The
// input side stalls only when a result is waiting unaccepted and the last character
// held in the input register needs the result register. The scheme is compared
// without regard to letter case, the host may hold bracketed ipv6 text,
// and a failed scheme or length check gives an all-zero result.
module tcp_uri_host_port_splitter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      char_valid,
	output logic                      char_ready,
	input  tuhps_pkg::char_beat_t     char_beat,
	output logic                      result_valid,
	input  logic                      result_ready,
	output tuhps_pkg::result_beat_t   result_beat
);
	import tuhps_pkg::*;

	logic              valid_s1;
	logic [7:0]        ch_s1;
	logic              last_s1;
	logic              move_s1;

	logic [POS_W-1:0]  pos_q;
	logic              prefix_good_q;
	scan_state_t       scan_q;
	scan_state_t       scan_nxt;
	logic              scan_en;
	logic              prefix_match;

	logic              result_valid_q;
	result_beat_t      result_q;
	result_beat_t      result_nxt;
	logic              frame_ok;
	logic              syntax_ok;

	assign move_s1 = valid_s1 && (!last_s1 || !result_valid_q || result_ready);
	assign char_ready = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			ch_s1 <= char_beat.ch;
			last_s1 <= char_beat.last;
		end
	end

	assign scan_en = (pos_q >= POS_W'(PREFIX_LEN)) && !last_s1
		&& (pos_q < POS_W'(MAX_URL_LENGTH));
	assign prefix_match = (pos_q >= POS_W'(PREFIX_LEN))
		|| (to_lower(ch_s1) == prefix_char(pos_q[3:0]));

	tuhps_scan u_scan (
		.en  (scan_en),
		.ch  (ch_s1),
		.pos (pos_q),
		.st  (scan_q),
		.nxt (scan_nxt)
	);

	// uri state, back to reset values after each last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			prefix_good_q <= 1'b1;
			scan_q <= '0;
		end else if (move_s1) begin
			if (last_s1) begin
				pos_q <= '0;
				prefix_good_q <= 1'b1;
				scan_q <= '0;
			end else begin
				if (pos_q < POS_W'(MAX_URL_LENGTH)) begin
					pos_q <= pos_q + 1'b1;
				end
				prefix_good_q <= prefix_good_q && prefix_match;
				scan_q <= scan_nxt;
			end
		end
	end

	assign frame_ok = prefix_good_q && (pos_q >= POS_W'(PREFIX_LEN))
		&& (pos_q <= POS_W'(LAST_POS_MAX));
	assign syntax_ok = scan_q.port_seen && !scan_q.bad_syntax;

	always_comb begin
		result_nxt = '0;
		if (frame_ok) begin
			result_nxt.uri_ok = syntax_ok;
			result_nxt.host_length = scan_q.host_len;
			result_nxt.port_start = scan_q.port_start;
			// no slash ended the port: it runs to the end of the uri
			if (syntax_ok && scan_q.port_len == '0) begin
				result_nxt.port_length = FIELD_W'(pos_q) + FIELD_W'(1) - scan_q.port_start;
			end else begin
				result_nxt.port_length = scan_q.port_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (move_s1 && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && last_s1) begin
			result_q <= result_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result_beat = result_q;

endmodule

// File: hdl/tuhps_port_checker.sv
// port-level checks of the splitter and their bind
`include "tcp_uri_host_port_splitter_macros.svh"

module tuhps_port_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    char_ready,
	input logic                    result_valid,
	input logic                    result_ready,
	input tuhps_pkg::result_beat_t result_beat
);
	import tuhps_pkg::*;

	// a stalled result stays offered
	`TUHPS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid)
	// a stalled result keeps its beat
	`TUHPS_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result_beat))
	// with the result register empty the input side never stalls
	`TUHPS_ASSERT_NOW(a_ready_when_empty, !result_valid, char_ready)
	// a good uri always carries a port position and a nonzero port length
	`TUHPS_ASSERT_NOW(a_ok_has_port, result_valid && result_beat.uri_ok,
		result_beat.port_start != '0 && result_beat.port_length != '0)

endmodule

bind tcp_uri_host_port_splitter tuhps_port_checker u_port_checker (.*);

// File: sim/tb.sv
// testbench for the uri host/port splitter: random and directed uris, checked per result
`timescale 1ns / 1ps

module tb;
	import tuhps_pkg::*;

	localparam string SCHEME = "opc.tcp://";

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         char_valid = 1'b0;
	logic         char_ready;
	char_beat_t   char_beat = '0;
	logic         result_valid;
	logic         result_ready = 1'b0;
	result_beat_t result_beat;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic [7:0] uri_chars[$];

	// predicts the split of each uri and holds the splits still to come out
	class uri_split_checker;
		logic [POS_W-1:0] pos;
		bit               scheme_ok;
		scan_state_t      st;
		result_beat_t     expected_splits[$];
		int               mismatches;

		function new();
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			pos = '0;
			scheme_ok = 1'b1;
			st = '0;
		endfunction

		function void scan(logic [7:0] c, logic [POS_W-1:0] p);
			if (st.in_port_part) begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					if (!st.port_seen) begin
						st.port_seen = 1'b1;
						st.port_start = FIELD_W'(p);
					end
				end else if (c == CH_SLASH && !st.bad_syntax) begin
					if (!st.port_seen) begin
						st.bad_syntax = 1'b1;
					end else begin
						st.port_len = FIELD_W'(p) - st.port_start;
						st.path_seen = 1'b1;
					end
				end else if (!st.port_seen || !st.path_seen) begin
					st.bad_syntax = 1'b1;
				end
			end else begin
				if (c == CH_COLON && !st.inside_brackets) begin
					st.host_len = FIELD_W'(p - POS_W'(PREFIX_LEN));
					st.in_port_part = 1'b1;
				end else if (c == CH_LBRACK) begin
					st.inside_brackets = 1'b1;
				end else if (c == CH_RBRACK) begin
					if (!st.inside_brackets) begin
						st.bad_syntax = 1'b1;
					end else begin
						st.inside_brackets = 1'b0;
					end
				end
			end
		endfunction

		function void note_char(char_beat_t b);
			logic [POS_W-1:0] p;
			logic [POS_W:0]   len;
			logic [7:0]       folded;
			logic [7:0]       want;
			logic [11:0]      plen;
			result_beat_t     split;
			p = pos;
			if (p < PREFIX_LEN) begin
				folded = (b.ch >= "A" && b.ch <= "Z") ? b.ch + 8'h20 : b.ch;
				want = SCHEME[p];
				if (folded != want) begin
					scheme_ok = 1'b0;
				end
			end else if (!b.last && p < MAX_URL_LENGTH) begin
				scan(b.ch, p);
			end
			if (!b.last) begin
				if (pos < MAX_URL_LENGTH) begin
					pos++;
				end
				return;
			end
			len = {1'b0, p} + 1'b1;
			split = '0;
			if (scheme_ok && len > PREFIX_LEN && len + TAIL_MARGIN <= MAX_URL_LENGTH) begin
				split.uri_ok = st.port_seen && !st.bad_syntax;
				split.host_length = st.host_len;
				split.port_start = st.port_start;
				plen = st.port_len;
				// no slash closed the port: it runs to the end of the uri
				if (split.uri_ok && plen == 0) begin
					plen = FIELD_W'(len) - st.port_start;
				end
				split.port_length = plen;
			end
			expected_splits.push_back(split);
			clear();
		endfunction

		function void check_result(result_beat_t got);
			result_beat_t e;
			if (expected_splits.size() == 0) begin
				$display("%0t unexpected result beat: expected none, actual %h", $time, got);
				mismatches++;
				return;
			end
			e = expected_splits.pop_front();
			if (got.uri_ok !== e.uri_ok) begin
				$display("%0t uri_ok: expected %0d, actual %0d", $time, e.uri_ok, got.uri_ok);
				mismatches++;
			end
			if (got.host_length !== e.host_length) begin
				$display("%0t host_length: expected %0d, actual %0d", $time,
					e.host_length, got.host_length);
				mismatches++;
			end
			if (got.port_start !== e.port_start) begin
				$display("%0t port_start: expected %0d, actual %0d", $time,
					e.port_start, got.port_start);
				mismatches++;
			end
			if (got.port_length !== e.port_length) begin
				$display("%0t port_length: expected %0d, actual %0d", $time,
					e.port_length, got.port_length);
				mismatches++;
			end
		endfunction
	endclass

	uri_split_checker splits = new();

	tcp_uri_host_port_splitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_beat(char_beat),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_beat(result_beat)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && char_ready) begin
				splits.note_char(char_beat);
			end
			if (result_valid && result_ready) begin
				splits.check_result(result_beat);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic push_char(input logic [7:0] c, input logic fin);
		char_beat_t b;
		b.ch = c;
		b.last = fin;
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_beat <= b;
		do @(posedge clk); while (!char_ready);
	endtask

	task automatic send_uri();
		for (int i = 0; i < uri_chars.size(); i++) begin
			push_char(uri_chars[i], i == uri_chars.size() - 1);
		end
	endtask

	// hold the sender off until every split has come out
	task automatic wait_drained();
		char_valid <= 1'b0;
		@(posedge clk);
		while (splits.expected_splits.size() != 0) @(posedge clk);
	endtask

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			uri_chars.push_back(s[i]);
		end
	endfunction

	function automatic void add_scheme(bit mixed);
		logic [7:0] c;
		for (int i = 0; i < SCHEME.len(); i++) begin
			c = SCHEME[i];
			if (mixed && c >= "a" && c <= "z" && $urandom_range(1)) begin
				c = c - 8'h20;
			end
			uri_chars.push_back(c);
		end
	endfunction

	task automatic send_text(string s);
		uri_chars.delete();
		add_text(s);
		send_uri();
	endtask

	function automatic void build_random_uri();
		string host_set = "abcdefghijklmnopqrstuvwxyz0123456789.-";
		string hex_set = "0123456789abcdef:";
		int kind;
		int n;
		uri_chars.delete();
		kind = $urandom_range(99);
		if (kind < 85) begin
			add_scheme(1'b1);
			if ($urandom_range(3) == 0) begin
				uri_chars.push_back(CH_LBRACK);
				n = $urandom_range(1, 8);
				repeat (n) uri_chars.push_back(hex_set[$urandom_range(16)]);
				if ($urandom_range(7) != 0) begin
					uri_chars.push_back(CH_RBRACK);
				end
			end else begin
				n = $urandom_range(0, 12);
				repeat (n) begin
					if ($urandom_range(24) == 0) begin
						uri_chars.push_back($urandom_range(1) ? CH_LBRACK : CH_RBRACK);
					end else begin
						uri_chars.push_back(host_set[$urandom_range(host_set.len() - 1)]);
					end
				end
			end
			if ($urandom_range(9) != 0) begin
				uri_chars.push_back(CH_COLON);
				n = $urandom_range(1, 5);
				repeat (n) uri_chars.push_back(CH_ZERO + 8'($urandom_range(9)));
				if ($urandom_range(1)) begin
					uri_chars.push_back(CH_SLASH);
					n = $urandom_range(0, 10);
					repeat (n) uri_chars.push_back(8'($urandom_range(32, 126)));
				end
			end
			// corrupt one character of the generated uri
			if (kind >= 70) begin
				uri_chars[$urandom_range(uri_chars.size() - 1)] = 8'($urandom_range(255));
			end
		end else if (kind < 93) begin
			n = $urandom_range(1, 30);
			repeat (n) uri_chars.push_back(8'($urandom_range(255)));
		end else begin
			// scheme plus host, cut back to between one and eleven characters
			add_scheme(1'b1);
			add_text("h:1");
			n = $urandom_range(1, 11);
			while (uri_chars.size() > n) uri_chars.pop_back();
		end
	endfunction

	task automatic random_phase(int n_chars);
		int sent;
		sent = 0;
		while (sent < n_chars) begin
			build_random_uri();
			send_uri();
			sent += uri_chars.size();
			if ($urandom_range(19) == 0) begin
				wait_drained();
			end
		end
		wait_drained();
	endtask

	task automatic run_directed();
		send_text("opc.tcp://host:4840/path");
		send_text("OPC.TCP://HOST:4840");
		send_text("Opc.Tcp://[fe80::1]:62541/ua");
		send_text("opc.tcp://[::1:4840/x");
		send_text("opc.tcp://h]x:1/a");
		send_text("opc.tcp://plainhost");
		send_text("opc.tcp://h:/p");
		send_text("opc.tcp://h:12a3/b");
		send_text("opc.tcp://h:1//a");
		send_text("opc.tcp://h:");
		send_text("opc.tcp://h:1x");
		send_text("opc.tcp://:0/");
		send_text("opc.tcp:/");
		send_text("opc.tcp://");
		send_text("opc.tcp://x");
		send_text("opd.tcp://h:1/");
		send_text("o");
		// an all-ones byte inside the port and an all-zero byte after the slash, then both alone
		uri_chars.delete();
		add_text("opc.tcp://h:9");
		uri_chars.push_back(8'hff);
		uri_chars.push_back(CH_SLASH);
		uri_chars.push_back(8'h00);
		send_uri();
		uri_chars.delete();
		uri_chars.push_back(8'hff);
		uri_chars.push_back(8'h00);
		send_uri();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 30;
		recv_idle_pct = 86;
		run_directed();
		wait_drained();
		random_phase(200);
		send_idle_pct = 86;
		recv_idle_pct = 30;
		random_phase(200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(200);
		repeat (20) @(posedge clk);
		if (splits.mismatches == 0 && splits.expected_splits.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
